[rtl/core/dbpc_pkg.sv]
package dbpc_pkg;

    localparam int FILTER_FRAC_BITS_DEF = 12;
    localparam int TIME_BITS_DEF        = 32;

    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int ANGLE_W     = 7;
    localparam int STATE_W     = 3;
    localparam int NOW_W       = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_TILT_PRESS = CFG_INDEX_W'(1);

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(1000);
    localparam logic [CFG_W-1:0] TILT_PRESS_RESET = CFG_W'(3000);

    localparam logic [ANGLE_W-1:0] ANGLE_UP_END = ANGLE_W'(0);
    localparam logic [ANGLE_W-1:0] ANGLE_DOWN   = ANGLE_W'(100);
    localparam logic [ANGLE_W-1:0] ANGLE_TILT   = ANGLE_W'(30);

    typedef enum logic [STATE_W-1:0] {
        MODE_OFF            = 3'd0,
        MODE_UP             = 3'd1,
        MODE_UP_END         = 3'd2,
        MODE_DOWN           = 3'd3,
        MODE_DOWN_END       = 3'd4,
        MODE_DOWN_END_ANGLE = 3'd5
    } mode_t;

    typedef struct packed {
        logic up;
        logic down;
    } press_t;

    typedef struct packed {
        mode_t              mode;
        logic [ANGLE_W-1:0] angle;
        logic               changed;
        logic               publish;
    } result_t;

endpackage

[rtl/core/double_button_press_classifier.sv]
// Classifies presses of an up and a down button from raw pin samples.
// Each input transfer carries one sample of both pins and a millisecond
// timestamp; each sample produces exactly one output transfer holding the
// press state, the angle target and the changed and publish flags.
// Both channels use valid and stall; a transfer happens on a rising edge
// with valid high and stall low.
// A sample goes into an input register, is filtered and classified, and
// lands in the result register, from which it is offered to the receiver.
// One sample is taken every cycle while in_stall is low; the filter and
// state update sit combinationally between the two registers.
// When the receiver stalls, the result register holds and the input
// register holds the next sample, so the input stalls once both are full.
// Reset clears both filters, the state (off), timers and angle, and sets
// the hold times to 1000 ms and 3000 ms. The user must write the hold times
// via the configuration port only with no sample in flight (not enforced).
module double_button_press_classifier #(
    parameter int FILTER_FRAC_BITS = dbpc_pkg::FILTER_FRAC_BITS_DEF,
    parameter int TIME_BITS        = dbpc_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dbpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dbpc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             up_pin,
    input  logic                             down_pin,
    input  logic [dbpc_pkg::NOW_W-1:0]       now_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [dbpc_pkg::STATE_W-1:0]     press_state,
    output logic [dbpc_pkg::ANGLE_W-1:0]     angle_percent,
    output logic                             changed,
    output logic                             publish
);

    logic [dbpc_pkg::CFG_W-1:0] long_press_reg;
    logic [dbpc_pkg::CFG_W-1:0] tilt_press_reg;
    logic                       in_valid_reg;
    logic                       up_pin_reg;
    logic                       down_pin_reg;
    logic [TIME_BITS-1:0]       now_reg;
    logic                       out_valid_reg;
    dbpc_pkg::result_t          result_reg;
    dbpc_pkg::result_t          result_next;
    dbpc_pkg::press_t           press;
    logic                       advance;
    logic                       in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= dbpc_pkg::LONG_PRESS_RESET;
            tilt_press_reg <= dbpc_pkg::TILT_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dbpc_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data;
                dbpc_pkg::CFG_TILT_PRESS: tilt_press_reg <= cfg_data;
                default:
                begin
                    long_press_reg <= long_press_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            up_pin_reg   <= up_pin;
            down_pin_reg <= down_pin;
            now_reg      <= now_ms[TIME_BITS-1:0];
        end
    end

    dbpc_filter #(
        .FRAC_BITS (FILTER_FRAC_BITS)
    ) u_up_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .pin     (up_pin_reg),
        .pressed (press.up)
    );

    dbpc_filter #(
        .FRAC_BITS (FILTER_FRAC_BITS)
    ) u_down_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance && !press.up),
        .pin     (down_pin_reg),
        .pressed (press.down)
    );

    dbpc_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .press         (press),
        .now           (now_reg),
        .long_press_ms (long_press_reg),
        .tilt_press_ms (tilt_press_reg),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign press_state   = result_reg.mode;
    assign angle_percent = result_reg.angle;
    assign changed       = result_reg.changed;
    assign publish       = result_reg.publish;

endmodule

[rtl/core/dbpc_filter.sv]
module dbpc_filter #(
    parameter int FRAC_BITS = dbpc_pkg::FILTER_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic pin,
    output logic pressed
);

    localparam int FW = FRAC_BITS + 4;
    localparam int XW = FW + 4;
    localparam int SHIFT = XW + 4;
    localparam int RW = SHIFT - 3;
    localparam longint unsigned RECIP = (64'd1 << SHIFT) / 10;
    localparam logic [FW-1:0] ONE  = FW'(1) << FRAC_BITS;
    localparam logic [FW-1:0] FIVE = FW'(5) << FRAC_BITS;

    logic [FW-1:0]    filter_reg;
    logic [FW-1:0]    filter_next;
    logic [XW-1:0]    scaled;
    logic [XW+RW-1:0] product;
    logic [FW-1:0]    quot_est;
    logic [XW-1:0]    remainder;
    logic [FW-1:0]    quot;

    // The pin term is a multiple of ten, so only nine tenths of the old value need dividing.
    assign scaled    = {filter_reg, 3'b000} + XW'(filter_reg);
    assign product   = (XW+RW)'(scaled) * (XW+RW)'(RW'(RECIP));
    assign quot_est  = product[SHIFT +: FW];
    assign remainder = scaled - (XW'({quot_est, 3'b000}) + XW'({quot_est, 1'b0}));
    assign quot      = (remainder >= XW'(10)) ? quot_est + FW'(1) : quot_est;

    assign filter_next = quot + (pin ? ONE : FW'(0));
    assign pressed     = filter_next > FIVE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= '0;
        end
        else if (en)
        begin
            filter_reg <= filter_next;
        end
    end

endmodule

[rtl/core/dbpc_fsm.sv]
module dbpc_fsm #(
    parameter int TIME_BITS = dbpc_pkg::TIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  dbpc_pkg::press_t           press,
    input  logic [TIME_BITS-1:0]       now,
    input  logic [dbpc_pkg::CFG_W-1:0] long_press_ms,
    input  logic [dbpc_pkg::CFG_W-1:0] tilt_press_ms,
    output dbpc_pkg::result_t          result
);

    dbpc_pkg::mode_t                mode_reg;
    dbpc_pkg::mode_t                mode_next;
    logic [TIME_BITS-1:0]           up_start_reg;
    logic [TIME_BITS-1:0]           up_start_next;
    logic [TIME_BITS-1:0]           down_start_reg;
    logic [TIME_BITS-1:0]           down_start_next;
    logic [dbpc_pkg::ANGLE_W-1:0]   angle_reg;
    logic [dbpc_pkg::ANGLE_W-1:0]   angle_next;
    logic                           changed;
    logic                           publish;
    logic [TIME_BITS-1:0]           up_elapsed;
    logic [TIME_BITS-1:0]           down_elapsed;
    logic                           up_long;
    logic                           down_long;
    logic                           down_tilt;

    assign up_elapsed   = now - up_start_reg;
    assign down_elapsed = now - down_start_reg;
    assign up_long      = up_elapsed > TIME_BITS'(long_press_ms);
    assign down_long    = down_elapsed > TIME_BITS'(long_press_ms);
    assign down_tilt    = down_elapsed > TIME_BITS'(tilt_press_ms);

    always_comb
    begin
        mode_next = mode_reg;
        if (press.up)
        begin
            case (mode_reg)
                dbpc_pkg::MODE_UP_END:
                begin
                    mode_next = mode_reg;
                end
                dbpc_pkg::MODE_UP:
                begin
                    if (up_long)
                    begin
                        mode_next = dbpc_pkg::MODE_UP_END;
                    end
                end
                default:
                begin
                    mode_next = dbpc_pkg::MODE_UP;
                end
            endcase
        end
        else if (press.down)
        begin
            case (mode_reg)
                dbpc_pkg::MODE_DOWN:
                begin
                    if (down_long)
                    begin
                        mode_next = dbpc_pkg::MODE_DOWN_END;
                    end
                end
                dbpc_pkg::MODE_DOWN_END:
                begin
                    if (down_tilt)
                    begin
                        mode_next = dbpc_pkg::MODE_DOWN_END_ANGLE;
                    end
                end
                dbpc_pkg::MODE_DOWN_END_ANGLE:
                begin
                    mode_next = mode_reg;
                end
                default:
                begin
                    mode_next = dbpc_pkg::MODE_DOWN;
                end
            endcase
        end
        else
        begin
            mode_next = dbpc_pkg::MODE_OFF;
        end
    end

    always_comb
    begin
        up_start_next   = up_start_reg;
        down_start_next = down_start_reg;
        angle_next      = angle_reg;
        changed         = 1'b0;
        publish         = 1'b0;
        if (press.up)
        begin
            case (mode_reg)
                dbpc_pkg::MODE_UP_END:
                begin
                    changed = 1'b0;
                end
                dbpc_pkg::MODE_UP:
                begin
                    if (up_long)
                    begin
                        angle_next = dbpc_pkg::ANGLE_UP_END;
                        changed    = 1'b1;
                    end
                end
                default:
                begin
                    up_start_next = now;
                    changed       = 1'b1;
                    publish       = 1'b1;
                end
            endcase
        end
        else if (press.down)
        begin
            case (mode_reg)
                dbpc_pkg::MODE_DOWN:
                begin
                    if (down_long)
                    begin
                        angle_next = dbpc_pkg::ANGLE_DOWN;
                        changed    = 1'b1;
                    end
                end
                dbpc_pkg::MODE_DOWN_END:
                begin
                    if (down_tilt)
                    begin
                        angle_next = dbpc_pkg::ANGLE_TILT;
                        changed    = 1'b1;
                    end
                end
                dbpc_pkg::MODE_DOWN_END_ANGLE:
                begin
                    changed = 1'b0;
                end
                default:
                begin
                    down_start_next = now;
                    angle_next      = dbpc_pkg::ANGLE_DOWN;
                    changed         = 1'b1;
                    publish         = 1'b1;
                end
            endcase
        end
        else if (mode_reg != dbpc_pkg::MODE_OFF)
        begin
            changed = (mode_reg == dbpc_pkg::MODE_UP) || (mode_reg == dbpc_pkg::MODE_DOWN);
            publish = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= dbpc_pkg::MODE_OFF;
            up_start_reg   <= '0;
            down_start_reg <= '0;
            angle_reg      <= '0;
        end
        else if (en)
        begin
            mode_reg       <= mode_next;
            up_start_reg   <= up_start_next;
            down_start_reg <= down_start_next;
            angle_reg      <= angle_next;
        end
    end

    assign result.mode    = mode_next;
    assign result.angle   = angle_next;
    assign result.changed = changed;
    assign result.publish = publish;

endmodule

[rtl/core/dbpc_checker.sv]
module dbpc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [dbpc_pkg::STATE_W-1:0]     press_state,
    input logic [dbpc_pkg::ANGLE_W-1:0]     angle_percent,
    input logic                             changed,
    input logic                             publish
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(press_state)
            && $stable(angle_percent) && $stable(changed) && $stable(publish))
        else $error("Stalled result changed before its transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && publish && !changed |-> press_state == dbpc_pkg::MODE_OFF)
        else $error("Publish without change outside a release.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (press_state == dbpc_pkg::MODE_DOWN
            || press_state == dbpc_pkg::MODE_DOWN_END)
        |-> angle_percent == dbpc_pkg::ANGLE_DOWN)
        else $error("Down press without the down angle target.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_state == dbpc_pkg::MODE_DOWN_END_ANGLE
        |-> angle_percent == dbpc_pkg::ANGLE_TILT)
        else $error("Tilt press without the tilt angle target.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_state == dbpc_pkg::MODE_UP_END
        |-> angle_percent == dbpc_pkg::ANGLE_UP_END)
        else $error("Up end press without the up end angle target.");

endmodule

bind double_button_press_classifier dbpc_checker u_dbpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .press_state   (press_state),
    .angle_percent (angle_percent),
    .changed       (changed),
    .publish       (publish)
);
